// ===== hw/rtl/dcrv_pkg.sv =====
// Shared types, constants and arithmetic helpers for the damped comb reverb vocal path.
package dcrv_pkg;

  localparam int DATA_W      = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] REG_RUNNING = 2'd0;
  localparam logic [1:0] REG_DEPTH   = 2'd1;
  localparam logic [1:0] REG_LEVEL   = 2'd2;

  localparam logic [16:0] Q15_ONE      = 17'd32768;
  localparam logic [15:0] DEPTH_MAX    = 16'd32768;
  localparam logic [15:0] BYPASS_DEPTH = 16'd656;

  localparam logic [14:0] K_LOWPASS  = 15'd23593;
  localparam logic [14:0] K_WET      = 15'd22938;
  localparam logic [14:0] K_WET_BASE = 15'd1966;
  localparam logic [14:0] K_DRY      = 15'd18022;
  localparam logic [14:0] K_DUCK     = 15'd19661;
  localparam logic [14:0] K_DUCK_BASE = 15'd4915;

  localparam logic signed [17:0] K_DAMP_HOLD = 18'sd20316;
  localparam logic signed [17:0] K_DAMP_IN   = 18'sd12452;
  localparam logic signed [17:0] K_FEEDBACK  = 18'sd24904;

  typedef enum logic [2:0] {
    F_IDLE,
    F_LOWPASS,
    F_WET,
    F_DRY,
    F_KCOEF,
    F_DUCK,
    F_PUSH
  } f_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_LOWPASS,
    B_DUCK,
    B_SEND,
    B_DAMP,
    B_CELL,
    B_FEEDBACK,
    B_DRY,
    B_LEVEL
  } b_state_t;

  typedef struct packed {
    logic                     stopped;
    logic                     bypass;
    logic signed [DATA_W-1:0] sample;
    logic [16:0]              a_lp;
    logic [14:0]              wet_amt;
    logic [16:0]              dry_amt;
    logic [16:0]              duck_v;
  } item_t;

  function automatic logic [11:0] line_length(input logic [1:0] sel);
    logic [11:0] len;
    unique case (sel)
      2'd0:    len = 12'd1687;
      2'd1:    len = 12'd1601;
      2'd2:    len = 12'd2053;
      default: len = 12'd2251;
    endcase
    return len;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat24(input logic signed [31:0] x);
    logic signed [DATA_W-1:0] y;
    if (x > 32'sd8388607) begin
      y = 24'sh7FFFFF;
    end else if (x < -32'sd8388608) begin
      y = -24'sh800000;
    end else begin
      y = x[DATA_W-1:0];
    end
    return y;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [DATA_W-1:0] x);
    logic signed [15:0] y;
    if (x > 24'sd32767) begin
      y = 16'sh7FFF;
    end else if (x < -24'sd32768) begin
      y = -16'sh8000;
    end else begin
      y = x[15:0];
    end
    return y;
  endfunction

endpackage

// ===== hw/rtl/dcrv_front.sv =====
// Front end: accepts samples, saturates depth and envelope, derives per-item coefficients.
module dcrv_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    running,
  input  logic [15:0]             depth,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] vocal_sample,
  input  logic [15:0]             kick_envelope,
  output logic                    q_valid,
  input  logic                    q_ready,
  output dcrv_pkg::item_t         q_item
);

  dcrv_pkg::f_state_t state, state_next;
  dcrv_pkg::item_t    item;

  logic [15:0] d_sat;
  logic [15:0] env_sat;
  logic [14:0] kcoef;

  logic [14:0] fa;
  logic [15:0] fb;
  logic [30:0] fprod;
  logic [31:0] fsum;
  logic [16:0] fr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcrv_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    q_valid    = 1'b0;
    fa         = dcrv_pkg::K_LOWPASS;
    fb         = d_sat;
    unique case (state)
      dcrv_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = running ? dcrv_pkg::F_LOWPASS : dcrv_pkg::F_PUSH;
        end
      end
      dcrv_pkg::F_LOWPASS: begin
        state_next = dcrv_pkg::F_WET;
      end
      dcrv_pkg::F_WET: begin
        fa         = dcrv_pkg::K_WET;
        state_next = dcrv_pkg::F_DRY;
      end
      dcrv_pkg::F_DRY: begin
        fa         = dcrv_pkg::K_DRY;
        state_next = dcrv_pkg::F_KCOEF;
      end
      dcrv_pkg::F_KCOEF: begin
        fa         = dcrv_pkg::K_DUCK;
        state_next = dcrv_pkg::F_DUCK;
      end
      dcrv_pkg::F_DUCK: begin
        fa         = kcoef;
        fb         = env_sat;
        state_next = dcrv_pkg::F_PUSH;
      end
      dcrv_pkg::F_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) begin
          state_next = dcrv_pkg::F_IDLE;
        end
      end
      default: state_next = dcrv_pkg::F_IDLE;
    endcase
  end

  assign fprod = 31'(fa) * 31'(fb);
  assign fsum  = 32'(fprod) + 32'd16384;
  assign fr    = fsum[31:15];

  always_ff @(posedge clk) begin
    unique case (state)
      dcrv_pkg::F_IDLE: begin
        if (in_valid) begin
          item.stopped <= ~running;
          item.sample  <= dcrv_pkg::DATA_W'(signed'(vocal_sample));
          item.bypass  <= (depth > dcrv_pkg::DEPTH_MAX ? dcrv_pkg::DEPTH_MAX : depth)
                          < dcrv_pkg::BYPASS_DEPTH;
          d_sat        <= depth > dcrv_pkg::DEPTH_MAX ? dcrv_pkg::DEPTH_MAX : depth;
          env_sat      <= kick_envelope > dcrv_pkg::DEPTH_MAX ? dcrv_pkg::DEPTH_MAX
                                                              : kick_envelope;
        end
      end
      dcrv_pkg::F_LOWPASS: item.a_lp    <= dcrv_pkg::Q15_ONE - fr;
      dcrv_pkg::F_WET:     item.wet_amt <= 15'(fr + 17'(dcrv_pkg::K_WET_BASE));
      dcrv_pkg::F_DRY:     item.dry_amt <= dcrv_pkg::Q15_ONE - fr;
      dcrv_pkg::F_KCOEF:   kcoef        <= 15'(fr + 17'(dcrv_pkg::K_DUCK_BASE));
      dcrv_pkg::F_DUCK:    item.duck_v  <= dcrv_pkg::Q15_ONE - fr;
      default: ;
    endcase
  end

  assign q_item = item;

endmodule

// ===== hw/rtl/dcrv_queue.sv =====
// Two-entry queue carrying classified items from the front end to the comb engine.
module dcrv_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dcrv_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output dcrv_pkg::item_t out_item
);

  localparam int PTR_W = $clog2(dcrv_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dcrv_pkg::QUEUE_DEPTH + 1);

  dcrv_pkg::item_t slots [dcrv_pkg::QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = count != CNT_W'(dcrv_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(dcrv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(dcrv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(dcrv_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_count_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");
`endif

endmodule

// ===== hw/rtl/dcrv_back.sv =====
// Comb engine: low-pass, ducking, damped feedback combs on one delay memory, output mix.
module dcrv_back #(
  parameter int COMB_COUNT   = 4,
  parameter int LINE_DEPTH   = 2304,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [15:0]                    level,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  dcrv_pkg::item_t                q_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] vocal_out,
  output logic signed [15:0]             filtered_vocal
);

  localparam int MEM_DEPTH = COMB_COUNT * LINE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int PW        = $clog2(LINE_DEPTH);
  localparam int LW        = PW + 1;
  localparam int CW        = ($clog2(COMB_COUNT) < 2) ? 2 : $clog2(COMB_COUNT);
  localparam int NXT       = (COMB_COUNT > 1) ? 1 : 0;
  localparam int WACC_W    = 25 + $clog2(COMB_COUNT);
  localparam logic [CW-1:0] LAST = CW'(COMB_COUNT - 1);
  localparam logic signed [30:0] OUT_MAX = 31'((32'sd1 <<< (SAMPLE_WIDTH - 1)) - 32'sd1);
  localparam logic signed [30:0] OUT_MIN = -OUT_MAX - 31'sd1;

  dcrv_pkg::b_state_t state, state_next;
  dcrv_pkg::item_t    item;

  logic signed [23:0]       lp;
  logic signed [23:0]       vd;
  logic signed [23:0]       ducked;
  logic signed [23:0]       send;
  logic signed [27:0]       dprod;
  logic signed [23:0]       lp_c;
  logic signed [23:0]       vocal;
  logic signed [WACC_W-1:0] wet_acc;
  logic [CW-1:0]            comb_idx;
  logic [AW-1:0]            base;
  logic [PW-1:0]            pos [COMB_COUNT];
  logic signed [23:0]       damp [COMB_COUNT];
  logic [COMB_COUNT-1:0]    filled;

  logic signed [23:0] mem [MEM_DEPTH];
  logic signed [23:0] rdata;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               mem_we;
  logic               out_load;

  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] prod;
  logic signed [42:0] rsum15;
  logic signed [42:0] rsum12;
  logic signed [27:0] r15;
  logic signed [30:0] r12;

  logic [LW-1:0]      len_cur;
  logic [LW-1:0]      pos_inc;
  logic               pos_wrap;
  logic signed [23:0] tap_rd;
  logic signed [23:0] lp_next;
  logic signed [23:0] cell_next;
  logic signed [23:0] wet_scaled;
  logic signed [31:0] wet_round;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(input logic signed [30:0] x);
    logic signed [SAMPLE_WIDTH-1:0] y;
    if (x > OUT_MAX) begin
      y = OUT_MAX[SAMPLE_WIDTH-1:0];
    end else if (x < OUT_MIN) begin
      y = OUT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      y = x[SAMPLE_WIDTH-1:0];
    end
    return y;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcrv_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      dcrv_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          state_next = q_item.stopped ? dcrv_pkg::B_LEVEL : dcrv_pkg::B_LOWPASS;
        end
      end
      dcrv_pkg::B_LOWPASS: state_next = dcrv_pkg::B_DUCK;
      dcrv_pkg::B_DUCK:    state_next = dcrv_pkg::B_SEND;
      dcrv_pkg::B_SEND:    state_next = dcrv_pkg::B_DAMP;
      dcrv_pkg::B_DAMP:    state_next = dcrv_pkg::B_CELL;
      dcrv_pkg::B_CELL:    state_next = dcrv_pkg::B_FEEDBACK;
      dcrv_pkg::B_FEEDBACK: begin
        mem_we     = 1'b1;
        state_next = (comb_idx == LAST) ? dcrv_pkg::B_DRY : dcrv_pkg::B_DAMP;
      end
      dcrv_pkg::B_DRY: state_next = dcrv_pkg::B_LEVEL;
      dcrv_pkg::B_LEVEL: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = dcrv_pkg::B_IDLE;
        end
      end
      default: state_next = dcrv_pkg::B_IDLE;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = 25'(item.sample) - 25'(lp);
    mul_b = $signed({1'b0, item.a_lp});
    unique case (state)
      dcrv_pkg::B_DUCK: begin
        mul_a = 25'(vd);
        mul_b = $signed({1'b0, item.duck_v});
      end
      dcrv_pkg::B_SEND: begin
        mul_a = 25'(ducked);
        mul_b = $signed({3'b000, item.wet_amt});
      end
      dcrv_pkg::B_DAMP: begin
        mul_a = 25'(damp[0]);
        mul_b = dcrv_pkg::K_DAMP_HOLD;
      end
      dcrv_pkg::B_CELL: begin
        mul_a = 25'(tap_rd);
        mul_b = dcrv_pkg::K_DAMP_IN;
      end
      dcrv_pkg::B_FEEDBACK: begin
        mul_a = 25'(lp_c);
        mul_b = dcrv_pkg::K_FEEDBACK;
      end
      dcrv_pkg::B_DRY: begin
        mul_a = 25'(ducked);
        mul_b = $signed({1'b0, item.dry_amt});
      end
      dcrv_pkg::B_LEVEL: begin
        mul_a = 25'(vocal);
        mul_b = $signed({2'b00, level});
      end
      default: ;
    endcase
  end

  assign prod   = 43'(mul_a) * 43'(mul_b);
  assign rsum15 = prod + 43'sd16384;
  assign rsum12 = prod + 43'sd2048;
  assign r15    = rsum15[42:15];
  assign r12    = rsum12[42:12];

  assign len_cur  = (LW'(dcrv_pkg::line_length(comb_idx[1:0])) > LW'(LINE_DEPTH))
                  ? LW'(LINE_DEPTH) : LW'(dcrv_pkg::line_length(comb_idx[1:0]));
  assign pos_inc  = LW'(pos[0]) + 1'b1;
  assign pos_wrap = pos_inc >= len_cur;
  assign tap_rd   = filled[0] ? rdata : 24'sd0;

  assign lp_next    = dcrv_pkg::sat24(32'(lp) + 32'(r15));
  assign cell_next  = dcrv_pkg::sat24(32'(send) + 32'(r15));
  assign wet_round  = (32'(wet_acc) + 32'sd2) >>> 2;
  assign wet_scaled = dcrv_pkg::sat24(wet_round);

  assign waddr = base + AW'(pos[0]);

  always_comb begin
    raddr = base + AW'(pos[0]);
    if (state == dcrv_pkg::B_FEEDBACK) begin
      raddr = (comb_idx == LAST) ? '0 : base + AW'(LINE_DEPTH) + AW'(pos[NXT]);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= cell_next;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp        <= '0;
      comb_idx  <= '0;
      base      <= '0;
      filled    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < COMB_COUNT; i++) begin
        pos[i]  <= '0;
        damp[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        dcrv_pkg::B_IDLE: begin
          if (q_valid) begin
            item <= q_item;
          end
        end
        dcrv_pkg::B_LOWPASS: begin
          lp <= lp_next;
          vd <= item.bypass ? item.sample : lp_next;
        end
        dcrv_pkg::B_DUCK: ducked <= dcrv_pkg::sat24(32'(r15));
        dcrv_pkg::B_SEND: begin
          send    <= dcrv_pkg::sat24(32'(r15));
          wet_acc <= '0;
        end
        dcrv_pkg::B_DAMP: dprod <= r15;
        dcrv_pkg::B_CELL: lp_c <= dcrv_pkg::sat24(32'(dprod) + 32'(r15));
        dcrv_pkg::B_FEEDBACK: begin
          wet_acc <= wet_acc + WACC_W'(lp_c);
          for (int i = 0; i < COMB_COUNT - 1; i++) begin
            pos[i]    <= pos[i+1];
            damp[i]   <= damp[i+1];
            filled[i] <= filled[i+1];
          end
          pos[COMB_COUNT-1]    <= pos_wrap ? '0 : pos_inc[PW-1:0];
          damp[COMB_COUNT-1]   <= lp_c;
          filled[COMB_COUNT-1] <= filled[0] | pos_wrap;
          if (comb_idx == LAST) begin
            comb_idx <= '0;
            base     <= '0;
          end else begin
            comb_idx <= comb_idx + 1'b1;
            base     <= base + AW'(LINE_DEPTH);
          end
        end
        dcrv_pkg::B_DRY: vocal <= dcrv_pkg::sat24(32'(r15) + 32'(wet_scaled));
        dcrv_pkg::B_LEVEL: begin
          if (out_load) begin
            vocal_out      <= item.stopped ? '0 : sat_out(r12);
            filtered_vocal <= item.stopped ? '0 : dcrv_pkg::sat16(vd);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pos_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == dcrv_pkg::B_DAMP || state == dcrv_pkg::B_CELL ||
     state == dcrv_pkg::B_FEEDBACK) |-> LW'(pos[0]) < len_cur)
    else $error("comb position beyond line length");

  a_ring_home: assert property (@(posedge clk) disable iff (rst)
    state == dcrv_pkg::B_DRY |-> (comb_idx == '0 && base == '0))
    else $error("comb ring not back at first comb");

  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && item.stopped) |=> (vocal_out == '0 && filtered_vocal == '0))
    else $error("stopped transaction gave nonzero result");
`endif

endmodule

// ===== hw/rtl/damped_comb_reverb_vocal_path.sv =====
// Top level of the damped comb reverb vocal path: config registers, front end, queue, engine.
// The comb engine shares one multiplier and one delay memory across all combs and works on one
// sample at a time; the queue lets the front end take the next sample meanwhile. A stopped
// transaction skips the coefficient, filter and comb states on both sides.
// Reset clears control state, the low-pass and comb state; a per-comb fill flag makes
// unwritten delay entries read as zero, so no clearing pass is needed.
module damped_comb_reverb_vocal_path #(
  parameter int COMB_COUNT   = 4,
  parameter int LINE_DEPTH   = 2304,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SAMPLE_WIDTH-1:0]        vocal_sample,
  input  logic [15:0]                    kick_envelope,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] vocal_out,
  output logic signed [15:0]             filtered_vocal,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_data
);

  logic        running;
  logic [15:0] depth;
  logic [15:0] level;

  logic            fq_valid;
  logic            fq_ready;
  dcrv_pkg::item_t fq_item;
  logic            qb_valid;
  logic            qb_ready;
  dcrv_pkg::item_t qb_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      depth   <= 16'd4915;
      level   <= 16'd9830;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dcrv_pkg::REG_RUNNING: running <= cfg_data[0];
        dcrv_pkg::REG_DEPTH:   depth   <= cfg_data;
        dcrv_pkg::REG_LEVEL:   level   <= cfg_data;
        default: ;
      endcase
    end
  end

  dcrv_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .running      (running),
    .depth        (depth),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vocal_sample (vocal_sample),
    .kick_envelope(kick_envelope),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_item       (fq_item)
  );

  dcrv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fq_valid),
    .in_ready (fq_ready),
    .in_item  (fq_item),
    .out_valid(qb_valid),
    .out_ready(qb_ready),
    .out_item (qb_item)
  );

  dcrv_back #(
    .COMB_COUNT  (COMB_COUNT),
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .level         (level),
    .q_valid       (qb_valid),
    .q_ready       (qb_ready),
    .q_item        (qb_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .vocal_out     (vocal_out),
    .filtered_vocal(filtered_vocal)
  );

endmodule

// ===== tb/damped_comb_reverb_vocal_path_tb.sv =====
// Self-checking testbench for the damped comb reverb vocal path: directed, random and stall tests.
module damped_comb_reverb_vocal_path_tb;

  localparam int  LINE_DEPTH     = 2304;
  localparam int  LIMIT_CYCLES   = 1000000;
  localparam int  RX_HOLD_CYCLES = 400;
  localparam int  TAIL_CYCLES    = 40;
  localparam int  PHASES         = 3;
  localparam int  PHASE_ITEMS    = 150;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam longint C_LP       = 23593;
  localparam longint C_WET      = 22938;
  localparam longint C_WET_BASE = 1966;
  localparam longint C_DRY      = 18022;
  localparam longint C_DUCK     = 19661;
  localparam longint C_DUCK_BASE = 4915;
  localparam longint C_HOLD     = 20316;
  localparam longint C_IN       = 12452;
  localparam longint C_FB       = 24904;
  localparam longint C_QUARTER  = 8192;
  localparam longint Q_ONE      = 32768;
  localparam longint BYPASS_LIM = 656;

  typedef struct packed {
    logic signed [15:0] vocal;
    logic signed [15:0] filtered;
  } vocal_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        vocal_sample;
  logic [15:0]        kick_envelope;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] vocal_out;
  logic signed [15:0] filtered_vocal;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  logic tx_idle_en;
  logic rx_idle_en;
  logic rx_hold_on = 1'b0;
  int   rx_wait;
  int   err_count = 0;
  int   cycle_count = 0;
  event rx_hold_ev;

  vocal_result_t expected_results[$];

  // predictor state and its copy of the registers
  logic        run_en    = 1'b0;
  logic [15:0] depth_q15 = 16'd4915;
  logic [15:0] level_q12 = 16'd9830;
  longint      lowpass_acc = 0;
  int          comb_line[4][LINE_DEPTH];
  int          comb_pos[4];
  longint      comb_damp[4];
  int          comb_taps[4] = '{1687, 1601, 2053, 2251};

  damped_comb_reverb_vocal_path i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .vocal_sample   (vocal_sample),
    .kick_envelope  (kick_envelope),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .vocal_out      (vocal_out),
    .filtered_vocal (filtered_vocal),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint rnd_shift(longint p, int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint q15_mul(longint a, longint b);
    return rnd_shift(a * b, 15);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint clip24(longint v);
    return clip(v, -8388608, 8388607);
  endfunction

  function automatic vocal_result_t reverb_predict(logic [15:0] vs, logic [15:0] env_in);
    longint v, d, env, a_lp, wet_amt, dry_amt, kcoef, duck_v;
    longint vd, ducked, send, wet, vocal, lp;
    int idx;
    vocal_result_t r;
    r = '0;
    if (!run_en) begin
      return r;
    end
    v   = $signed(vs);
    env = (env_in > 16'd32768) ? Q_ONE : longint'(env_in);
    d   = (depth_q15 > 16'd32768) ? Q_ONE : longint'(depth_q15);
    a_lp    = Q_ONE - q15_mul(C_LP, d);
    wet_amt = C_WET_BASE + q15_mul(C_WET, d);
    dry_amt = Q_ONE - q15_mul(C_DRY, d);
    kcoef   = C_DUCK_BASE + q15_mul(C_DUCK, d);
    duck_v  = Q_ONE - q15_mul(kcoef, env);
    lowpass_acc = clip24(lowpass_acc + q15_mul(a_lp, v - lowpass_acc));
    vd     = (d < BYPASS_LIM) ? v : lowpass_acc;
    ducked = clip24(q15_mul(vd, duck_v));
    send   = clip24(q15_mul(ducked, wet_amt));
    wet = 0;
    for (int c = 0; c < 4; c++) begin
      idx = comb_pos[c];
      if (idx >= comb_taps[c]) idx = 0;
      lp = clip24(q15_mul(comb_damp[c], C_HOLD) + q15_mul(comb_line[c][idx], C_IN));
      comb_damp[c] = lp;
      wet += lp;
      comb_line[c][idx] = int'(clip24(send + q15_mul(lp, C_FB)));
      idx++;
      if (idx >= comb_taps[c]) idx = 0;
      comb_pos[c] = idx;
    end
    wet   = clip24(q15_mul(wet, C_QUARTER));
    vocal = clip24(q15_mul(ducked, dry_amt) + wet);
    vocal = rnd_shift(vocal * longint'(level_q12), 12);
    r.vocal    = 16'(clip(vocal, -32768, 32767));
    r.filtered = 16'(clip(vd, -32768, 32767));
    return r;
  endfunction

  // receiver: random per-transaction stalls, plus a long hold on request
  always @(posedge clk) begin : rx_side
    int gap;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (rx_hold_on) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      gap = rx_idle_en ? $urandom_range(0, 6) : 0;
      rx_wait   <= gap;
      out_ready <= (gap == 0);
    end else if (rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : rx_hold_timer
    forever begin
      @(rx_hold_ev);
      rx_hold_on <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_hold_on <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    vocal_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected transaction vocal_out=%0d filtered_vocal=%0d",
                 $time, vocal_out, filtered_vocal);
      end else begin
        want = expected_results.pop_front();
        if (want.vocal !== vocal_out) begin
          err_count++;
          $display("%0t: vocal_out mismatch expected %0d actual %0d",
                   $time, want.vocal, vocal_out);
        end
        if (want.filtered !== filtered_vocal) begin
          err_count++;
          $display("%0t: filtered_vocal mismatch expected %0d actual %0d",
                   $time, want.filtered, filtered_vocal);
        end
      end
    end
  end

  task automatic send_sample(input logic [15:0] vs, input logic [15:0] env);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    vocal_sample  <= vs;
    kick_envelope <= env;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(reverb_predict(vs, env));
  endtask

  task automatic cfg_put(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dcrv_pkg::REG_RUNNING: run_en = data[0];
      dcrv_pkg::REG_DEPTH:   depth_q15 = data;
      dcrv_pkg::REG_LEVEL:   level_q12 = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic run, input logic [15:0] dep, input logic [15:0] lvl);
    cfg_put(dcrv_pkg::REG_RUNNING, {15'($urandom), run});
    cfg_put(dcrv_pkg::REG_DEPTH, dep);
    cfg_put(dcrv_pkg::REG_LEVEL, lvl);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_vocal();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_envelope();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 32768));
  endfunction

  task automatic test_stopped_output();
    send_sample(16'h7FFF, 16'd32768);
    send_sample(16'h8000, 16'hFFFF);
    send_sample(16'hFFFF, 16'd0);
    drain_results();
  endtask

  // transport on, depth and level still at their reset values
  task automatic test_reset_coefficients();
    cfg_put(dcrv_pkg::REG_RUNNING, 16'd1);
    cfg_valid <= 1'b0;
    send_sample(16'h7FFF, 16'd0);
    send_sample(16'h8000, 16'd16384);
    send_sample(16'd12345, 16'd32768);
    drain_results();
  endtask

  task automatic test_depth_extremes();
    logic [15:0] depths[5] = '{16'd0, 16'd655, 16'd656, 16'd32768, 16'hFFFF};
    logic [15:0] levels[5] = '{16'hFFFF, 16'd0, 16'd4096, 16'hFFFF, 16'd4096};
    for (int i = 0; i < 5; i++) begin
      set_config(1'b1, depths[i], levels[i]);
      send_sample(16'h7FFF, 16'd0);
      send_sample(16'h8000, 16'd32768);
      send_sample(16'($urandom), 16'd40000);
      drain_results();
    end
  endtask

  task automatic test_unknown_register();
    cfg_put(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    send_sample(16'd20000, 16'd8192);
    send_sample(16'hC000, 16'd0);
    drain_results();
  endtask

  // random configurations, with idle gaps on each side enabled at random after the first phase
  task automatic test_random_phases();
    logic        run;
    logic [15:0] dep, lvl;
    for (int ph = 0; ph < PHASES; ph++) begin
      run = (ph == 0) || ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 5))
        0:       dep = 16'($urandom_range(0, 655));
        1:       dep = 16'd32768;
        2:       dep = 16'($urandom_range(32769, 65535));
        default: dep = 16'($urandom_range(656, 32767));
      endcase
      case ($urandom_range(0, 5))
        0:       lvl = 16'd0;
        1:       lvl = 16'hFFFF;
        2:       lvl = 16'($urandom);
        default: lvl = 16'($urandom_range(0, 8192));
      endcase
      set_config(run, dep, lvl);
      tx_idle_en <= (ph != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_en <= (ph != 0) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_sample(rand_vocal(), rand_envelope());
      drain_results();
    end
  endtask

  task automatic test_output_backpressure();
    set_config(1'b1, 16'($urandom_range(656, 32768)), 16'd4096);
    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b1;
    -> rx_hold_ev;
    for (int n = 0; n < 30; n++)
      send_sample(rand_vocal(), rand_envelope());
    drain_results();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    vocal_sample  = '0;
    kick_envelope = '0;
    cfg_valid     = 1'b0;
    cfg_index     = dcrv_pkg::REG_RUNNING;
    cfg_data      = '0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_stopped_output();
    test_reset_coefficients();
    test_depth_extremes();
    test_unknown_register();
    test_random_phases();
    test_output_backpressure();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
